// ----- rtl/swcc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swcc_pkg
// Types, codes and constants shared by the send window congestion control.
// ----------------------------------------------------------------------------
package swcc_pkg;

	// Hard ceiling on the window, on top of the configured maximum
	localparam int unsigned WINDOW_LIMIT = 255;

	localparam int unsigned WIN_W   = 8;
	localparam int unsigned RATE_W  = 16;
	localparam int unsigned CNT_W   = 16;
	localparam int unsigned TS_W    = 32;
	localparam int unsigned CFG_AW  = 3;
	localparam int unsigned CFG_DW  = 16;

	// Operation codes
	localparam logic [1:0] OP_SEND    = 2'd0;
	localparam logic [1:0] OP_REPLY   = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;
	localparam logic [1:0] OP_RESET   = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_AW-1:0] REG_INIT_WINDOW    = 3'd0;
	localparam logic [CFG_AW-1:0] REG_INIT_SSTHRESH  = 3'd1;
	localparam logic [CFG_AW-1:0] REG_INIT_MAX       = 3'd2;
	localparam logic [CFG_AW-1:0] REG_INIT_RATE      = 3'd3;
	localparam logic [CFG_AW-1:0] REG_TIMEOUT_THRESH = 3'd4;
	localparam logic [CFG_AW-1:0] REG_BACKOFF_EN     = 3'd5;
	localparam logic [CFG_AW-1:0] REG_RESP_TO_LIMIT  = 3'd6;
	localparam logic [CFG_AW-1:0] REG_YOUNG_LIMIT    = 3'd7;

	typedef struct packed {
		logic [1:0]      op;
		logic [TS_W-1:0] timestamp;
	} req_t;

	typedef struct packed {
		logic             refused;
		logic [WIN_W-1:0] window_size;
		logic [WIN_W-1:0] in_flight;
		logic             collapsed;
	} rsp_t;

endpackage

`default_nettype wire

// ----- rtl/swcc_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swcc_if
// Valid/ready channels carrying requests and results of the send window.
// ----------------------------------------------------------------------------
interface swcc_req_if import swcc_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface swcc_rsp_if import swcc_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/send_window_congestion_control.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// send_window_congestion_control
// Probe send window with slow start, congestion avoidance, per-slot rate
// limiting and timeout backoff collapse.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per transaction (send, reply, timeout, window
//   reset) with a timestamp; rsp returns exactly one result per request:
//   refused flag, window size, in-flight count and collapse flag.
//   Configuration registers are written through cfg_we/cfg_index/cfg_wdata
//   while no request is in progress; they take effect at the next window
//   reset operation (or directly, for the backoff controls).
// Timing:
//   A request accepted into the input register passes on to the result register,
//   which raises rsp.valid; a low rsp.ready holds it there.
//   Throughput is one transaction per cycle while rsp.ready stays high; the
//   state update is a single compare-and-increment stage, so each result
//   follows the previous one in the next cycle.
// Reset:
//   arst_n clears both stages, loads the register defaults and sets the
//   window state from them.
// Back-pressure:
//   When rsp.ready is low the result register holds; the input register
//   keeps one further transaction and req.ready drops only once both are
//   full.
// ----------------------------------------------------------------------------
module send_window_congestion_control
	import swcc_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	swcc_req_if.sink           req,
	swcc_rsp_if.source         rsp,
	input  wire                cfg_we,
	input  wire [CFG_AW-1:0]   cfg_index,
	input  wire [CFG_DW-1:0]   cfg_wdata
);

	// configuration registers
	logic [WIN_W-1:0]  init_window_q, init_ssthresh_q, init_max_q, timeout_thresh_q;
	logic [RATE_W-1:0] init_rate_q;
	logic              backoff_en_q;
	logic [CNT_W-1:0]  resp_to_limit_q, young_limit_q;

	// window state
	logic [WIN_W-1:0]  outstanding_q, window_q, ssthresh_q, max_q, avoid_q, phase_q;
	logic [RATE_W-1:0] rate_q, slot_sends_q;
	logic [TS_W-1:0]   slot_time_q;
	logic [CNT_W-1:0]  timeouts_q, replies_q;
	logic              responsive_q;

	// pipeline
	logic              vld_s1;
	req_t              req_s1;
	logic              out_vld_q;
	rsp_t              rsp_q;
	logic              advance;

	assign advance   = !out_vld_q || rsp.ready;
	assign req.ready = !vld_s1 || advance;
	assign rsp.valid = out_vld_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_window_q    <= WIN_W'(10);
			init_ssthresh_q  <= WIN_W'(64);
			init_max_q       <= WIN_W'(255);
			init_rate_q      <= RATE_W'(65535);
			timeout_thresh_q <= WIN_W'(3);
			backoff_en_q     <= 1'b0;
			resp_to_limit_q  <= CNT_W'(10);
			young_limit_q    <= CNT_W'(10);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INIT_WINDOW:    init_window_q    <= cfg_wdata[WIN_W-1:0];
				REG_INIT_SSTHRESH:  init_ssthresh_q  <= cfg_wdata[WIN_W-1:0];
				REG_INIT_MAX:       init_max_q       <= cfg_wdata[WIN_W-1:0];
				REG_INIT_RATE:      init_rate_q      <= cfg_wdata[RATE_W-1:0];
				REG_TIMEOUT_THRESH: timeout_thresh_q <= cfg_wdata[WIN_W-1:0];
				REG_BACKOFF_EN:     backoff_en_q     <= cfg_wdata[0];
				REG_RESP_TO_LIMIT:  resp_to_limit_q  <= cfg_wdata[CNT_W-1:0];
				REG_YOUNG_LIMIT:    young_limit_q    <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= req.data;
		end
	end

	// next-state logic
	logic [WIN_W-1:0]  outstanding_d, window_d, ssthresh_d, max_d, avoid_d, phase_d;
	logic [RATE_W-1:0] rate_d, slot_sends_d;
	logic [TS_W-1:0]   slot_time_d;
	logic [CNT_W-1:0]  timeouts_d, replies_d;
	logic              responsive_d;
	logic              refused, collapsed;

	always_comb begin
		logic [RATE_W-1:0] eff_sends;
		logic [WIN_W:0]    avoid_nx;
		logic [WIN_W:0]    phase_nx;
		logic [WIN_W-1:0]  win_grown;
		logic              can_grow;

		outstanding_d = outstanding_q;
		window_d      = window_q;
		ssthresh_d    = ssthresh_q;
		max_d         = max_q;
		avoid_d       = avoid_q;
		phase_d       = phase_q;
		rate_d        = rate_q;
		slot_sends_d  = slot_sends_q;
		slot_time_d   = slot_time_q;
		timeouts_d    = timeouts_q;
		replies_d     = replies_q;
		responsive_d  = responsive_q;
		refused       = 1'b0;
		collapsed     = 1'b0;
		eff_sends     = slot_sends_q;

		can_grow  = (window_q < max_q) && (32'(window_q) < WINDOW_LIMIT)
			&& (window_q != '1);
		win_grown = can_grow ? window_q + WIN_W'(1) : window_q;
		avoid_nx  = {1'b0, avoid_q} + (WIN_W+1)'(1);
		phase_nx  = {1'b0, phase_q} + (WIN_W+1)'(1);

		case (req_s1.op)
			OP_SEND: begin
				if (req_s1.timestamp > slot_time_q) begin
					slot_time_d = req_s1.timestamp;
					eff_sends   = '0;
				end
				slot_sends_d = eff_sends;
				if (eff_sends >= rate_q || outstanding_q >= window_q) begin
					refused = 1'b1;
				end else begin
					slot_sends_d  = eff_sends + RATE_W'(1);
					outstanding_d = outstanding_q + WIN_W'(1);
				end
			end
			OP_RESET: begin
				outstanding_d = '0;
				window_d      = init_window_q;
				ssthresh_d    = init_ssthresh_q;
				max_d         = init_max_q;
				rate_d        = init_rate_q;
				slot_time_d   = '0;
				slot_sends_d  = '0;
				avoid_d       = '0;
				timeouts_d    = '0;
				replies_d     = '0;
				phase_d       = '0;
				responsive_d  = 1'b0;
			end
			default: begin
				if (outstanding_q != '0) begin
					outstanding_d = outstanding_q - WIN_W'(1);
				end
				if (req_s1.op == OP_TIMEOUT) begin
					if (timeouts_q != '1) begin
						timeouts_d = timeouts_q + CNT_W'(1);
					end
					if (backoff_en_q && responsive_q && replies_q <= young_limit_q) begin
						if (phase_nx >= {1'b0, timeout_thresh_q}) begin
							phase_d   = '0;
							collapsed = 1'b1;
						end else begin
							phase_d = phase_nx[WIN_W-1:0];
						end
					end
				end else begin
					if (timeouts_q < resp_to_limit_q) begin
						responsive_d = 1'b1;
					end
					if (replies_q != '1) begin
						replies_d = replies_q + CNT_W'(1);
					end
					phase_d = '0;
				end
				if (collapsed) begin
					window_d   = WIN_W'(1);
					ssthresh_d = WIN_W'(1);
					max_d      = WIN_W'(1);
					rate_d     = RATE_W'(1);
				end else if (window_q <= ssthresh_q) begin
					window_d = win_grown;
				end else if (avoid_nx >= {1'b0, window_q}) begin
					// a full window of answers: one step of avoidance growth
					avoid_d  = '0;
					window_d = win_grown;
				end else begin
					avoid_d = avoid_nx[WIN_W-1:0];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
			window_q      <= WIN_W'(10);
			ssthresh_q    <= WIN_W'(64);
			max_q         <= WIN_W'(255);
			rate_q        <= RATE_W'(65535);
			slot_time_q   <= '0;
			slot_sends_q  <= '0;
			avoid_q       <= '0;
			timeouts_q    <= '0;
			replies_q     <= '0;
			phase_q       <= '0;
			responsive_q  <= 1'b0;
			out_vld_q     <= 1'b0;
		end else if (advance) begin
			out_vld_q <= vld_s1;
			if (vld_s1) begin
				outstanding_q <= outstanding_d;
				window_q      <= window_d;
				ssthresh_q    <= ssthresh_d;
				max_q         <= max_d;
				rate_q        <= rate_d;
				slot_time_q   <= slot_time_d;
				slot_sends_q  <= slot_sends_d;
				avoid_q       <= avoid_d;
				timeouts_q    <= timeouts_d;
				replies_q     <= replies_d;
				phase_q       <= phase_d;
				responsive_q  <= responsive_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			rsp_q.refused     <= refused;
			rsp_q.window_size <= window_d;
			rsp_q.in_flight   <= outstanding_d;
			rsp_q.collapsed   <= collapsed;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/swcc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swcc_checker
// Port-level checks on the send window, bound to the top level.
// ----------------------------------------------------------------------------
module swcc_checker
	import swcc_pkg::*;
(
	input wire       clk,
	input wire       arst_n,
	input wire       req_valid,
	input wire       req_ready,
	input wire       rsp_valid,
	input wire       rsp_ready,
	input wire rsp_t rsp_data
);

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// a send refusal is never also a collapse
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_data.refused && rsp_data.collapsed))
		else $error("refused and collapsed together");

	// collapse leaves a window of one probe
	a_collapse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.collapsed |-> rsp_data.window_size == WIN_W'(1))
		else $error("collapse without window of one");

	// an accepted transaction passes the input and result registers when the receiver is ready
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
		else $error("result missing after transaction");

endmodule

bind send_window_congestion_control swcc_checker u_swcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire

// ----- sim/send_window_congestion_control_tb.sv -----
// ----------------------------------------------------------------------------
// send_window_congestion_control_tb
// Drives send, reply, timeout and window reset transactions into the send
// window under several register settings, with random gaps on both channels,
// and checks every result against a cycle-free model of the window state.
// ----------------------------------------------------------------------------
module send_window_congestion_control_tb;
	import swcc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	typedef struct {
		logic [WIN_W-1:0]  init_window;
		logic [WIN_W-1:0]  init_ssthresh;
		logic [WIN_W-1:0]  init_max;
		logic [RATE_W-1:0] init_rate;
		logic [7:0]        timeout_thresh;
		logic              backoff_en;
		logic [CNT_W-1:0]  resp_to_limit;
		logic [CNT_W-1:0]  young_limit;
	} window_cfg_t;

	typedef struct {
		logic [WIN_W-1:0]  in_flight;
		logic [WIN_W-1:0]  window;
		logic [WIN_W-1:0]  ssthresh;
		logic [WIN_W-1:0]  max_win;
		logic [RATE_W-1:0] send_cap;
		logic [TS_W-1:0]   slot_ts;
		logic [RATE_W-1:0] slot_count;
		logic [7:0]        avoid_steps;
		logic [CNT_W-1:0]  timeouts_seen;
		logic [CNT_W-1:0]  replies_seen;
		logic [7:0]        run_phase;
		logic              responsive;
	} window_state_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CFG_AW-1:0]  cfg_index;
	logic [CFG_DW-1:0]  cfg_wdata;

	swcc_req_if req_ch ();
	swcc_rsp_if rsp_ch ();

	send_window_congestion_control uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	window_cfg_t   cfg;
	window_state_t win;
	rsp_t          window_results_q[$];
	rsp_t          oldest_result;
	rsp_t          got_result;

	int unsigned error_count;
	int unsigned results_seen;
	int unsigned cycle_count;
	logic [TS_W-1:0] traffic_ts;
	bit          burst_mode;
	int unsigned rsp_stall_pct;
	int unsigned hold_len;
	int unsigned hold_asked;
	int unsigned hold_taken;
	int unsigned hold_left;
	int unsigned stall_left;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				window_results_q.size());
			$display("[send_window_congestion_control] ERROR");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// ---------------------------------------------------------------- model

	function automatic window_cfg_t default_cfg();
		window_cfg_t c;
		c.init_window    = 8'd10;
		c.init_ssthresh  = 8'd64;
		c.init_max       = 8'd255;
		c.init_rate      = 16'd65535;
		c.timeout_thresh = 8'd3;
		c.backoff_en     = 1'b0;
		c.resp_to_limit  = 16'd10;
		c.young_limit    = 16'd10;
		return c;
	endfunction

	function automatic void load_window_defaults();
		win.in_flight     = '0;
		win.window        = cfg.init_window;
		win.ssthresh      = cfg.init_ssthresh;
		win.max_win       = cfg.init_max;
		win.send_cap      = cfg.init_rate;
		win.slot_ts       = '0;
		win.slot_count    = '0;
		win.avoid_steps   = '0;
		win.timeouts_seen = '0;
		win.replies_seen  = '0;
		win.run_phase     = '0;
		win.responsive    = 1'b0;
	endfunction

	function automatic void grow_by_one();
		if (win.window < win.max_win && win.window < WINDOW_LIMIT && win.window != 8'hFF)
			win.window++;
	endfunction

	function automatic void grow_window_step();
		int unsigned next_count;
		if (win.window <= win.ssthresh) begin
			grow_by_one();
		end else begin
			// congestion avoidance: one step per window's worth of answers
			next_count = win.avoid_steps + 1;
			if (next_count >= win.window) begin
				win.avoid_steps = '0;
				grow_by_one();
			end else begin
				win.avoid_steps = next_count[7:0];
			end
		end
	endfunction

	function automatic rsp_t apply_window_op(logic [1:0] op, logic [TS_W-1:0] ts);
		rsp_t        res;
		int unsigned next_phase;
		res = '0;
		case (op)
			OP_SEND: begin
				if (ts > win.slot_ts) begin
					win.slot_ts    = ts;
					win.slot_count = '0;
				end
				if ({1'b0, win.slot_count} + 17'd1 > win.send_cap ||
						win.in_flight >= win.window) begin
					res.refused = 1'b1;
				end else begin
					win.slot_count++;
					win.in_flight++;
				end
			end
			OP_RESET: begin
				load_window_defaults();
			end
			default: begin
				if (win.in_flight != 0)
					win.in_flight--;
				if (op == OP_TIMEOUT) begin
					if (win.timeouts_seen != 16'hFFFF)
						win.timeouts_seen++;
					if (cfg.backoff_en && win.responsive &&
							win.replies_seen <= cfg.young_limit) begin
						next_phase = win.run_phase + 1;
						if (next_phase >= cfg.timeout_thresh) begin
							win.run_phase = '0;
							res.collapsed = 1'b1;
						end else begin
							win.run_phase = next_phase[7:0];
						end
					end
				end else begin
					if (win.timeouts_seen < cfg.resp_to_limit)
						win.responsive = 1'b1;
					if (win.replies_seen != 16'hFFFF)
						win.replies_seen++;
					win.run_phase = '0;
				end
				if (res.collapsed) begin
					win.window     = 8'd1;
					win.ssthresh   = 8'd1;
					win.max_win    = 8'd1;
					win.send_cap   = 16'd1;
				end else begin
					grow_window_step();
				end
			end
		endcase
		res.window_size = win.window;
		res.in_flight   = win.in_flight;
		return res;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("[%0t] result %0d: %s is %0d, expected %0d", $realtime, results_seen, what,
			got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got_result = rsp_ch.data;
			if (window_results_q.size() == 0) begin
				report_mismatch("unexpected result, window_size", got_result.window_size, 0);
			end else begin
				oldest_result = window_results_q.pop_front();
				if (got_result.refused !== oldest_result.refused)
					report_mismatch("refused", got_result.refused, oldest_result.refused);
				if (got_result.window_size !== oldest_result.window_size)
					report_mismatch("window_size", got_result.window_size,
						oldest_result.window_size);
				if (got_result.in_flight !== oldest_result.in_flight)
					report_mismatch("in_flight", got_result.in_flight, oldest_result.in_flight);
				if (got_result.collapsed !== oldest_result.collapsed)
					report_mismatch("collapsed", got_result.collapsed, oldest_result.collapsed);
			end
			results_seen++;
		end
	end

	// result side: random stalls, plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_asked != hold_taken) begin
			hold_taken    <= hold_asked;
			hold_left     <= hold_len;
			rsp_ch.ready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			rsp_ch.ready  <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left    <= stall_left - 1;
			rsp_ch.ready  <= 1'b0;
		end else begin
			rsp_ch.ready  <= 1'b1;
			if ($urandom_range(0, 99) < rsp_stall_pct)
				stall_left <= pick_gap();
		end
	end

	// ---------------------------------------------------------------- drivers

	task automatic send_op(logic [1:0] op, logic [TS_W-1:0] ts);
		int unsigned gap;
		gap = burst_mode ? 0 : pick_gap();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.data.op        <= op;
		req_ch.data.timestamp <= ts;
		do @(posedge clk); while (!req_ch.ready);
		window_results_q.push_back(apply_window_op(op, ts));
	endtask

	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		while (window_results_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	// registers only move while idle; a window reset then loads them
	task automatic apply_config(window_cfg_t c);
		wait_for_results();
		write_reg(REG_INIT_WINDOW, CFG_DW'(c.init_window));
		write_reg(REG_INIT_SSTHRESH, CFG_DW'(c.init_ssthresh));
		write_reg(REG_INIT_MAX, CFG_DW'(c.init_max));
		write_reg(REG_INIT_RATE, c.init_rate);
		write_reg(REG_TIMEOUT_THRESH, CFG_DW'(c.timeout_thresh));
		write_reg(REG_BACKOFF_EN, CFG_DW'(c.backoff_en));
		write_reg(REG_RESP_TO_LIMIT, c.resp_to_limit);
		write_reg(REG_YOUNG_LIMIT, c.young_limit);
		cfg_we <= 1'b0;
		cfg = c;
		send_op(OP_RESET, $urandom());
	endtask

	task automatic hold_results(int unsigned cycles);
		hold_len = cycles;
		hold_asked++;
	endtask

	function automatic logic [TS_W-1:0] next_timestamp();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
		end else if (r < 88) begin
			traffic_ts += $urandom_range(1, 3);
		end else if (r < 97) begin
			return traffic_ts - $urandom_range(1, 5);
		end else begin
			traffic_ts = $urandom();
		end
		return traffic_ts;
	endfunction

	task automatic random_traffic(int unsigned count, int unsigned timeout_pct);
		int unsigned r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 2)
				send_op(OP_RESET, $urandom());
			else if (r < 6)
				send_op(2'($urandom_range(0, 3)), $urandom());
			else if (r < 52)
				send_op(OP_SEND, next_timestamp());
			else if ($urandom_range(0, 99) < timeout_pct)
				send_op(OP_TIMEOUT, $urandom());
			else
				send_op(OP_REPLY, $urandom());
		end
	endtask

	function automatic window_cfg_t random_cfg();
		window_cfg_t c;
		c.init_window    = 8'($urandom_range(1, 24));
		c.init_ssthresh  = 8'($urandom_range(1, 32));
		c.init_max       = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(1, 40));
		c.init_rate      = ($urandom_range(0, 3) == 0) ? 16'd65535 : 16'($urandom_range(1, 6));
		c.timeout_thresh = 8'($urandom_range(0, 6));
		c.backoff_en     = 1'($urandom_range(0, 1));
		c.resp_to_limit  = 16'($urandom_range(0, 20));
		c.young_limit    = 16'($urandom_range(0, 30));
		return c;
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_directed_defaults();
		send_op(OP_SEND, 32'd0);
		send_op(OP_SEND, 32'd0);
		send_op(OP_SEND, 32'd1);
		send_op(OP_REPLY, 32'd0);
		send_op(OP_TIMEOUT, 32'hFFFF_FFFF);
		// answers that drain the flight, then find nothing in flight
		repeat (3) send_op(OP_REPLY, $urandom());
		send_op(OP_SEND, 32'hFFFF_FFFF);
		send_op(OP_SEND, 32'h5555_AAAA);
		send_op(OP_SEND, 32'hAAAA_5555);
		send_op(OP_RESET, 32'd0);
		// fill the window, the last one is refused
		repeat (11) send_op(OP_SEND, 32'd7);
		wait_for_results();
	endtask

	task automatic test_zero_registers();
		window_cfg_t c;
		c = '{default: '0};
		c.backoff_en    = 1'b1;
		c.resp_to_limit = 16'hFFFF;
		c.young_limit   = 16'hFFFF;
		apply_config(c);
		send_op(OP_SEND, 32'd3);
		send_op(OP_REPLY, 32'd0);
		// threshold of zero: every timeout collapses
		send_op(OP_TIMEOUT, 32'd0);
		send_op(OP_TIMEOUT, 32'd0);
		send_op(OP_SEND, 32'd3);
		send_op(OP_SEND, 32'd3);
		send_op(OP_SEND, 32'd4);
		send_op(OP_REPLY, 32'd0);
		send_op(OP_SEND, 32'd4);
		wait_for_results();
	endtask

	task automatic test_floor_settings();
		window_cfg_t c;
		c = '{8'd1, 8'd1, 8'd1, 16'd1, 8'd1, 1'b1, 16'd0, 16'd0};
		apply_config(c);
		random_traffic(40, 40);
		wait_for_results();
	endtask

	task automatic test_ceiling_settings();
		window_cfg_t c;
		c = '{8'd255, 8'd255, 8'd255, 16'hFFFF, 8'd255, 1'b1, 16'hFFFF, 16'hFFFF};
		apply_config(c);
		random_traffic(60, 50);
		// window of 200 below a big ceiling: slow start all the way up
		c.init_window = 8'd200;
		apply_config(c);
		repeat (60) send_op(OP_REPLY, $urandom());
		wait_for_results();
	endtask

	task automatic test_backoff_collapse();
		window_cfg_t c;
		c = default_cfg();
		c.backoff_en = 1'b1;
		apply_config(c);
		send_op(OP_REPLY, 32'd0);
		repeat (3) send_op(OP_TIMEOUT, 32'd0);
		repeat (3) send_op(OP_TIMEOUT, 32'd0);
		send_op(OP_REPLY, 32'd0);
		repeat (2) send_op(OP_TIMEOUT, 32'd0);
		send_op(OP_REPLY, 32'd0);
		// target no longer young: no collapse
		repeat (10) send_op(OP_REPLY, 32'd0);
		repeat (3) send_op(OP_TIMEOUT, 32'd0);
		wait_for_results();
	endtask

	task automatic test_window_growth();
		window_cfg_t c;
		c = default_cfg();
		// window above the cap stays put
		c.init_window   = 8'd40;
		c.init_ssthresh = 8'd10;
		c.init_max      = 8'd20;
		apply_config(c);
		repeat (6) send_op(OP_REPLY, 32'd0);
		c.init_window   = 8'd4;
		c.init_ssthresh = 8'd2;
		c.init_max      = 8'd12;
		apply_config(c);
		repeat (40) begin
			send_op(OP_SEND, next_timestamp());
			send_op(OP_SEND, next_timestamp());
			send_op(($urandom_range(0, 3) == 0) ? OP_TIMEOUT : OP_REPLY, $urandom());
			send_op(OP_REPLY, $urandom());
		end
		wait_for_results();
	endtask

	task automatic test_rate_limit();
		window_cfg_t c;
		c = default_cfg();
		c.init_window = 8'd50;
		c.init_rate   = 16'd3;
		apply_config(c);
		repeat (15) begin
			traffic_ts += $urandom_range(0, 1);
			repeat ($urandom_range(2, 5)) send_op(OP_SEND, traffic_ts);
			repeat ($urandom_range(1, 4)) send_op(OP_REPLY, $urandom());
		end
		wait_for_results();
	endtask

	task automatic test_backpressure();
		apply_config(default_cfg());
		hold_results(300);
		burst_mode = 1'b1;
		random_traffic(40, 30);
		// back to back with the result side always ready
		rsp_stall_pct = 0;
		random_traffic(60, 30);
		burst_mode = 1'b0;
		rsp_stall_pct = 20;
		wait_for_results();
	endtask

	task automatic test_random_settings();
		repeat (5) begin
			apply_config(random_cfg());
			random_traffic(110, $urandom_range(20, 60));
		end
		wait_for_results();
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		req_ch.valid  = 1'b0;
		req_ch.data   = '0;
		rsp_ch.ready  = 1'b0;
		error_count   = 0;
		results_seen  = 0;
		cycle_count   = 0;
		traffic_ts    = '0;
		burst_mode    = 1'b0;
		rsp_stall_pct = 20;
		hold_len      = 0;
		hold_asked    = 0;
		hold_taken    = 0;
		hold_left     = 0;
		stall_left    = 0;
		cfg = default_cfg();
		load_window_defaults();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_zero_registers();
		test_backoff_collapse();
		test_floor_settings();
		test_ceiling_settings();
		test_window_growth();
		test_rate_limit();
		test_backpressure();
		test_random_settings();

		wait_for_results();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("[send_window_congestion_control] OK");
		else
			$display("[send_window_congestion_control] ERROR");
		$finish;
	end

endmodule
